@@ hdl/wab_pkg.sv @@
// ----------------------------------------------------------------------------
// wab_pkg
// shared types and constants of the wrapping alpha blend blitter
// ----------------------------------------------------------------------------
`default_nettype none

package wab_pkg;

  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;
  localparam int unsigned DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned PIX_W      = 32;

  localparam int unsigned COORD_W    = 7;
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SUM_W      = POS_W + 1;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MUL_STEPS  = 7;
  localparam int unsigned K_W        = $clog2(MUL_STEPS + 1);

  localparam logic [CH_W-1:0] COLOR_MAX = 8'd255;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  typedef logic [3:0][CH_W-1:0] wab_pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_OFFSET_X = 2'd2,
    CFG_OFFSET_Y = 2'd3
  } wab_cfg_e;

  typedef enum logic [1:0] {
    REQ_BLEND = 2'd0,
    REQ_COPY  = 2'd1,
    REQ_READ  = 2'd2
  } wab_req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_MODX,
    ST_MODY,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_WRITE,
    ST_OUT
  } wab_state_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [CH_W-1:0]         src_red;
    logic [CH_W-1:0]         src_green;
    logic [CH_W-1:0]         src_blue;
    logic [CH_W-1:0]         src_alpha;
  } wab_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] wrapped_x;
    logic [COORD_W-1:0] wrapped_y;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [CH_W-1:0]    out_alpha;
  } wab_out_t;

endpackage

`default_nettype wire

@@ hdl/wab_ram.sv @@
// ----------------------------------------------------------------------------
// wab_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wab_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/wab_fmod.sv @@
// ----------------------------------------------------------------------------
// wab_fmod
// iterative floor modulo of a signed sum by a small unsigned size, two bits
// per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wab_fmod (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [wab_pkg::SUM_W-1:0]  value_i,
  input  wire logic [wab_pkg::SIZE_W-1:0]        mod_i,
  output logic                                   done_o,
  output logic [wab_pkg::COORD_W-1:0]            res_o
);
  import wab_pkg::*;

  localparam int unsigned MAG_W = SUM_W + 1;
  localparam int unsigned ITER  = MAG_W / 2;
  localparam int unsigned CNT_W = $clog2(ITER);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] mag_q;
  logic [COORD_W-1:0] rem_q, rem_d;
  logic [COORD_W-1:0] res_q;
  logic [COORD_W-1:0] fix;
  logic             neg_q;
  logic [SIZE_W-1:0] mod_q;
  logic [SIZE_W-1:0] t1, t2;
  logic [SUM_W-1:0] mag_in;

  assign mag_in = value_i[SUM_W-1] ? SUM_W'(-value_i) : SUM_W'(value_i);

  always_comb begin
    t1 = {rem_q, mag_q[MAG_W-1]};
    if (t1 >= mod_q) begin
      t1 = t1 - mod_q;
    end
    t2 = {t1[COORD_W-1:0], mag_q[MAG_W-2]};
    if (t2 >= mod_q) begin
      t2 = t2 - mod_q;
    end
    rem_d = t2[COORD_W-1:0];
    fix   = (neg_q && (rem_d != '0)) ? COORD_W'(mod_q - {1'b0, rem_d}) : rem_d;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= {1'b0, mag_in};
      rem_q <= '0;
      neg_q <= value_i[SUM_W-1];
      mod_q <= mod_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[MAG_W-3:0], 2'b00};
      rem_q <= rem_d;
      if (cnt_q == CNT_W'(ITER - 1)) begin
        res_q <= fix;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ hdl/wab_mul.sv @@
// ----------------------------------------------------------------------------
// wab_mul
// shared 8x8 multiplier with registered product and exact divide by 255
// ----------------------------------------------------------------------------
`default_nettype none

module wab_mul (
  input  wire logic                      clk_i,
  input  wire logic [wab_pkg::CH_W-1:0]  a_i,
  input  wire logic [wab_pkg::CH_W-1:0]  b_i,
  output logic      [wab_pkg::CH_W-1:0]  quo_o
);
  import wab_pkg::*;

  localparam int unsigned PROD_W = 2 * CH_W;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W:0]   acc;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // floor(p / 255) for p up to 255*255
  assign acc   = (PROD_W+1)'(prod_q) + (PROD_W+1)'(prod_q >> CH_W) + 1'b1;
  assign quo_o = acc[PROD_W-1:CH_W];

endmodule

`default_nettype wire

@@ hdl/wrapping_alpha_blend_blitter.sv @@
// ----------------------------------------------------------------------------
// wrapping_alpha_blend_blitter
// one word at a time, the next taken the cycle after the result is
// registered; each word has its position wrapped by two passes of the shared
// modulo unit (x, then y), and a blend adds seven passes of the shared
// multiplier
// after reset the frame store is cleared one pixel a cycle,
// during which no input word is taken; configuration writes are taken always
// ----------------------------------------------------------------------------
`default_nettype none

module wrapping_alpha_blend_blitter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire wab_pkg::wab_in_t                 in_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output wab_pkg::wab_out_t                     out_word_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [wab_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [wab_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import wab_pkg::*;

  wab_state_e state_q, state_d;

  logic [SIZE_W-1:0]       width_q, height_q;
  logic signed [POS_W-1:0] offx_q, offy_q;

  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic [K_W-1:0]          k_q, k_d;
  logic [K_W-1:0]          step;
  logic                    out_valid_q;
  wab_out_t                out_q;

  logic [1:0]              req_q;
  wab_pix_t                src_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [SIZE_W-1:0]       w_q, h_q, w_d, h_d;
  logic [COORD_W-1:0]      x_q, x_d, y_q, y_d;
  wab_pix_t                pix_q, pix_d;

  logic                    in_acc;
  logic                    out_load;

  logic                    fm_start;
  logic signed [SUM_W-1:0] fm_value;
  logic [SIZE_W-1:0]       fm_mod;
  logic                    fm_done;
  logic [COORD_W-1:0]      fm_res;

  logic [CH_W-1:0]         mul_a, mul_b, mul_quo;

  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, pix_addr;
  wab_pix_t                ram_wdata, ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    if (width_q == '0) begin
      w_d = SIZE_W'(1);
    end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
      w_d = SIZE_W'(MAX_WIDTH);
    end else begin
      w_d = width_q;
    end
    if (height_q == '0) begin
      h_d = SIZE_W'(1);
    end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
      h_d = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_d = height_q;
    end
  end

  assign pix_addr = ADDR_W'(ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x_q);
  assign step     = k_q - 1'b1;

  wab_fmod u_fmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fm_start),
    .value_i (fm_value),
    .mod_i   (fm_mod),
    .done_o  (fm_done),
    .res_o   (fm_res)
  );

  wab_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .quo_o (mul_quo)
  );

  wab_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pix_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    k_d       = k_q;
    pix_d     = pix_q;
    x_d       = x_q;
    y_d       = y_q;
    fm_start  = 1'b0;
    fm_value  = sum_x_q;
    fm_mod    = w_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = pix_q;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        fm_start = 1'b1;
        state_d  = ST_MODX;
      end
      ST_MODX: begin
        if (fm_done) begin
          x_d      = fm_res;
          fm_start = 1'b1;
          fm_value = sum_y_q;
          fm_mod   = h_q;
          state_d  = ST_MODY;
        end
      end
      ST_MODY: begin
        fm_value = sum_y_q;
        fm_mod   = h_q;
        if (fm_done) begin
          y_d     = fm_res;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        case (req_q)
          REQ_BLEND: begin
            pix_d           = '0;
            pix_d[CH_ALPHA] = src_q[CH_ALPHA];
            k_d             = '0;
            state_d         = ST_MUL;
          end
          REQ_COPY: begin
            pix_d   = src_q;
            state_d = ST_WRITE;
          end
          default: begin
            pix_d   = ram_rdata;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_MUL: begin
        // even steps src*a, odd steps dst*(255-a), last step dst alpha
        if (k_q != K_W'(MUL_STEPS)) begin
          if (!k_q[0] && (k_q != K_W'(MUL_STEPS - 1))) begin
            mul_a = src_q[k_q[2:1]];
            mul_b = src_q[CH_ALPHA];
          end else begin
            mul_a = ram_rdata[k_q[2:1]];
            mul_b = COLOR_MAX - src_q[CH_ALPHA];
          end
        end
        if (k_q != '0) begin
          pix_d[step[2:1]] = pix_q[step[2:1]] + mul_quo;
        end
        if (k_q == K_W'(MUL_STEPS)) begin
          state_d = ST_WRITE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      width_q     <= SIZE_W'(MAX_WIDTH);
      height_q    <= SIZE_W'(MAX_HEIGHT);
      offx_q      <= '0;
      offy_q      <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:    width_q  <= cfg_wdata_i[SIZE_W-1:0];
          CFG_HEIGHT:   height_q <= cfg_wdata_i[SIZE_W-1:0];
          CFG_OFFSET_X: offx_q   <= cfg_wdata_i;
          CFG_OFFSET_Y: offy_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q           <= in_word_i.req_type;
      src_q[CH_RED]   <= in_word_i.src_red;
      src_q[CH_GREEN] <= in_word_i.src_green;
      src_q[CH_BLUE]  <= in_word_i.src_blue;
      src_q[CH_ALPHA] <= in_word_i.src_alpha;
      sum_x_q         <= SUM_W'(in_word_i.pos_x) + SUM_W'(offx_q);
      sum_y_q         <= SUM_W'(in_word_i.pos_y) + SUM_W'(offy_q);
      w_q             <= w_d;
      h_q             <= h_d;
    end
    x_q   <= x_d;
    y_q   <= y_d;
    pix_q <= pix_d;
    if (out_load) begin
      out_q.wrapped_x <= x_q;
      out_q.wrapped_y <= y_q;
      out_q.out_red   <= pix_q[CH_RED];
      out_q.out_green <= pix_q[CH_GREEN];
      out_q.out_blue  <= pix_q[CH_BLUE];
      out_q.out_alpha <= pix_q[CH_ALPHA];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while a word is in flight");

  a_coord_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (({1'b0, x_q} < w_q) && ({1'b0, y_q} < h_q)))
    else $error("wrapped coordinate outside the frame size");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_CLEAR) ||
                ((state_q == ST_WRITE) && ((req_q == REQ_BLEND) || (req_q == REQ_COPY)))))
    else $error("frame store written outside clear or write step");

endmodule

`default_nettype wire

@@ test/wrapping_alpha_blend_blitter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapping_alpha_blend_blitter_test
// self-checking bench for the wrapping alpha blend blitter: a scoreboard keeps
// its own frame store and register copy, wraps every position by floor modulo,
// blends, overwrites or reads the pixel and compares each returned word field
// by field; directed words hit the edges, random phases sweep the settings
// ----------------------------------------------------------------------------

import wab_pkg::*;

class blit_scoreboard;
  logic [3:0][CH_W-1:0] frame [DEPTH];
  logic [SIZE_W-1:0]    width_reg = 8'd128;
  logic [SIZE_W-1:0]    height_reg = 8'd128;
  logic signed [15:0]   off_x = '0;
  logic signed [15:0]   off_y = '0;
  wab_out_t             pending_pixels [$];
  int                   errors = 0;
  int                   checked = 0;
  int                   n_blend = 0;
  int                   n_copy = 0;
  int                   n_read = 0;

  function new();
    foreach (frame[i]) frame[i] = '0;
  endfunction

  function void set_reg(wab_cfg_e idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_WIDTH:    width_reg = v[SIZE_W-1:0];
      CFG_HEIGHT:   height_reg = v[SIZE_W-1:0];
      CFG_OFFSET_X: off_x = v;
      CFG_OFFSET_Y: off_y = v;
      default: ;
    endcase
  endfunction

  function int wrap_coord(int v, int size, int limit);
    int m;
    int r;
    m = size;
    if (m == 0) m = 1;
    if (m > limit) m = limit;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function void apply_word(wab_in_t w);
    int col;
    int row;
    int a;
    int ia;
    logic [3:0][CH_W-1:0] src;
    logic [3:0][CH_W-1:0] px;
    wab_out_t e;
    col = wrap_coord(int'($signed(w.pos_x)) + int'(off_x), int'(width_reg),
                     int'(MAX_WIDTH));
    row = wrap_coord(int'($signed(w.pos_y)) + int'(off_y), int'(height_reg),
                     int'(MAX_HEIGHT));
    src = {w.src_alpha, w.src_blue, w.src_green, w.src_red};
    px = frame[row * MAX_WIDTH + col];
    case (w.req_type)
      REQ_BLEND: begin
        a = int'(src[CH_ALPHA]);
        ia = 255 - a;
        for (int c = CH_RED; c <= CH_BLUE; c++)
          px[c] = 8'((int'(src[c]) * a) / 255 + (int'(px[c]) * ia) / 255);
        px[CH_ALPHA] = 8'(a + (int'(px[CH_ALPHA]) * ia) / 255);
        n_blend++;
      end
      REQ_COPY: begin
        px = src;
        n_copy++;
      end
      default: n_read++;
    endcase
    frame[row * MAX_WIDTH + col] = px;
    e.wrapped_x = col[COORD_W-1:0];
    e.wrapped_y = row[COORD_W-1:0];
    e.out_red   = px[CH_RED];
    e.out_green = px[CH_GREEN];
    e.out_blue  = px[CH_BLUE];
    e.out_alpha = px[CH_ALPHA];
    pending_pixels.push_back(e);
  endfunction

  task report(string what, int got, int want);
    errors++;
    $display("%0t mismatch on %s: got %0d, expected %0d (word %0d)",
             $time, what, got, want, checked);
  endtask

  task check_pixel(wab_out_t got);
    wab_out_t e;
    if (pending_pixels.size() == 0) begin
      report("unexpected word", int'(got), 0);
      return;
    end
    e = pending_pixels.pop_front();
    if (got.wrapped_x !== e.wrapped_x)
      report("wrapped_x", int'(got.wrapped_x), int'(e.wrapped_x));
    if (got.wrapped_y !== e.wrapped_y)
      report("wrapped_y", int'(got.wrapped_y), int'(e.wrapped_y));
    if (got.out_red !== e.out_red)
      report("out_red", int'(got.out_red), int'(e.out_red));
    if (got.out_green !== e.out_green)
      report("out_green", int'(got.out_green), int'(e.out_green));
    if (got.out_blue !== e.out_blue)
      report("out_blue", int'(got.out_blue), int'(e.out_blue));
    if (got.out_alpha !== e.out_alpha)
      report("out_alpha", int'(got.out_alpha), int'(e.out_alpha));
    checked++;
  endtask
endclass

module wrapping_alpha_blend_blitter_test;
  localparam int IDLE_LIMIT = 60000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 146;
  localparam int RANDOM_PHASES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  wab_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  wab_out_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  blit_scoreboard sb = new();
  int quiet_cycles = 0;
  int burst_left = 0;
  int phases = 0;
  bit held = 1'b0;

  wrapping_alpha_blend_blitter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) sb.check_pixel(out_word_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int mode;
    int seg;
    int hold_left;
    bit stall;
    hold_left = 0;
    forever begin
      mode = $urandom_range(0, 2);
      seg = $urandom_range(10, 150);
      repeat (seg) begin
        @(negedge clk_i);
        if (!held && sb.checked >= HOLD_AT) begin
          held = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          stall = 1'b1;
          hold_left--;
        end else begin
          case (mode)
            0: stall = 1'b0;
            1: stall = ($urandom_range(0, 9) < 3);
            default: stall = ($urandom_range(0, 9) < 8);
          endcase
        end
        out_stall_i <= stall;
      end
    end
  end

  task write_reg(input wab_cfg_e idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task program_config(input logic [SIZE_W-1:0] wd, input logic [SIZE_W-1:0] ht,
                      input logic [15:0] ox, input logic [15:0] oy);
    write_reg(CFG_WIDTH, {8'($urandom), wd});
    write_reg(CFG_HEIGHT, {8'($urandom), ht});
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  task send_word(input wab_in_t w);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.apply_word(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task end_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task wait_drained();
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  function wab_in_t make_word(logic [1:0] req, int x, int y,
                              int r, int g, int b, int a);
    wab_in_t w;
    w.req_type = req;
    w.pos_x = 16'(x);
    w.pos_y = 16'(y);
    w.src_red = 8'(r);
    w.src_green = 8'(g);
    w.src_blue = 8'(b);
    w.src_alpha = 8'(a);
    return w;
  endfunction

  function wab_in_t random_word();
    int k;
    int x;
    int y;
    int a;
    logic [1:0] req;
    k = $urandom_range(0, 99);
    if (k < 45) req = REQ_BLEND;
    else if (k < 65) req = REQ_COPY;
    else if (k < 90) req = REQ_READ;
    else req = REQ_UNUSED;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      x = $urandom;
      y = $urandom;
    end else if (k < 8) begin
      x = int'($urandom_range(0, 40)) - 20;
      y = int'($urandom_range(0, 40)) - 20;
    end else begin
      x = $urandom_range(0, 1) ? 32767 : -32768;
      y = $urandom_range(0, 1) ? 32767 : -32768;
    end
    k = $urandom_range(0, 99);
    a = (k < 15) ? 0 : (k < 30) ? 255 : $urandom_range(0, 255);
    return make_word(req, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), a);
  endfunction

  initial begin
    wab_in_t directed [$];
    logic [SIZE_W-1:0] wd;
    logic [SIZE_W-1:0] ht;
    logic [15:0] ox;
    logic [15:0] oy;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: cleared store, corners and signed extremes
    directed = '{
      make_word(REQ_READ, 0, 0, 1, 2, 3, 4),
      make_word(REQ_COPY, 0, 0, 10, 20, 30, 40),
      make_word(REQ_BLEND, 0, 0, 200, 100, 50, 128),
      make_word(REQ_BLEND, 0, 0, 255, 255, 255, 0),
      make_word(REQ_BLEND, 128, 0, 17, 34, 51, 255),
      make_word(REQ_UNUSED, 0, 0, 255, 255, 255, 255),
      make_word(REQ_COPY, 32767, -32768, 255, 255, 255, 255),
      make_word(REQ_BLEND, -32768, 32767, 90, 0, 255, 77),
      make_word(REQ_COPY, -1, -1, 0, 128, 255, 200),
      make_word(REQ_READ, -1, -1, 0, 0, 0, 0),
      make_word(REQ_BLEND, 127, 127, 255, 255, 255, 254),
      make_word(REQ_READ, 128, 129, 0, 0, 0, 0)
    };
    foreach (directed[i]) send_word(directed[i]);
    end_phase();

    // zero size acts as one, offsets at opposite extremes
    wait_drained();
    program_config(8'd0, 8'd0, 16'sd32767, -16'sd32768);
    directed = '{
      make_word(REQ_COPY, 32767, 32767, 1, 2, 3, 4),
      make_word(REQ_BLEND, -32768, -32768, 250, 5, 128, 1),
      make_word(REQ_BLEND, 5, -7, 9, 9, 9, 0),
      make_word(REQ_UNUSED, 1, 1, 255, 255, 255, 255)
    };
    foreach (directed[i]) send_word(directed[i]);
    end_phase();

    // oversize clamps to the full store, most negative coordinate sum
    wait_drained();
    program_config(8'd255, 8'd200, -16'sd32768, -16'sd32768);
    directed = '{
      make_word(REQ_COPY, -32768, -32768, 11, 22, 33, 44),
      make_word(REQ_BLEND, 32767, 32767, 0, 0, 0, 100),
      make_word(REQ_READ, 32767, -32768, 0, 0, 0, 0),
      make_word(REQ_UNUSED, -32768, 32767, 0, 0, 0, 0)
    };
    foreach (directed[i]) send_word(directed[i]);
    end_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      ox = 16'($urandom);
      oy = 16'($urandom);
      case (p)
        0: begin wd = 8'd1; ht = 8'd1; end
        1: begin wd = 8'd0; ht = 8'd0; end
        2: begin wd = 8'd255; ht = 8'd255; end
        3: begin wd = 8'd128; ht = 8'd128; ox = 16'sd32767; oy = 16'sd32767; end
        4: begin wd = 8'd128; ht = 8'd128; ox = -16'sd32768; oy = -16'sd32768; end
        5: begin wd = 8'd129; ht = 8'd1; end
        default: begin
          wd = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(0, 255));
          ht = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(0, 255));
        end
      endcase
      wait_drained();
      program_config(wd, ht, ox, oy);
      repeat (PHASE_WORDS) send_word(random_word());
      end_phase();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d words (%0d blend, %0d overwrite, %0d read) over %0d settings",
             sb.n_blend + sb.n_copy + sb.n_read, sb.n_blend, sb.n_copy, sb.n_read,
             phases + 1);
    $display("%0d results checked, long output hold-off %0s", sb.checked,
             held ? "exercised" : "not reached");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/wab_pkg.sv
hdl/wab_ram.sv
hdl/wab_fmod.sv
hdl/wab_mul.sv
hdl/wrapping_alpha_blend_blitter.sv
test/wrapping_alpha_blend_blitter_test.sv
